FILE: rtl/core/sssc_pkg.sv
// Shared types, constants and the exp mantissa table for the selective scan core.
// No dependencies.
package sssc_pkg;

  localparam int unsigned CHANNELS_DEF = 64;
  localparam int unsigned STATES_DEF   = 16;
  localparam int unsigned CH_W         = 6;
  localparam int unsigned ST_W         = 4;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ACC_W        = 48;
  localparam int unsigned FRAC_W       = 16;
  localparam logic [17:0] LOG2E_Q16    = 18'd94548;

  // Input item layout in in_tdata (lowest bit first).
  localparam int unsigned IN_DATA_W  = 176;
  localparam int unsigned OUT_DATA_W = 40;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // 2^(i/16) in unsigned Q2.16, i = 0..16
  function automatic logic [17:0] pow2_tab(input logic [4:0] idx);
    logic [17:0] v;
    unique case (idx)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88752;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110218;
      5'd13: v = 18'd115065;
      5'd14: v = 18'd120152;
      5'd15: v = 18'd125434;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

  function automatic q16_t sat32(input logic signed [63:0] v);
    q16_t r;
    if (v > 64'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/core/selective_state_space_scan_core.sv
// Top level of the selective state-space scan element engine.
// Depends on sssc_pkg; holds the hidden-state memory and the shared multiplier.
//
// Each accepted item passes through the accept in the idle state, a
// memory read, then eight steps. Seven of those steps use one 33x33 signed
// multiplier, for delta*a, p*log2(e), the table interpolation, delta*b,
// (delta*b)*x, e*h and c*h'. The eighth writes the new hidden state back before
// the c*h' step. in_tready is high only in the idle state. A result for an item
// flagged last_state (in_tlast) goes to an output register, so the next item can
// be taken while it waits. The final step of a later last_state item holds for
// as long as an earlier result is still waiting there. After reset, a clearing
// pass over all CHANNELS*STATES entries zeroes the memory; no item is accepted then.
module selective_state_space_scan_core #(
  parameter int unsigned CHANNELS = sssc_pkg::CHANNELS_DEF,
  parameter int unsigned STATES   = sssc_pkg::STATES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // channel[6], state_index[4], x_value, step_size, decay_coeff, in_proj,
  // out_proj, 6 zero bits
  input  logic [sssc_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,   // last_state
  input  logic                               in_tuser,   // seq_start
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_channel[6], y_value[32], 2 zero bits
  output logic [sssc_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import sssc_pkg::*;

  localparam int unsigned DEPTH = CHANNELS * STATES;
  localparam int unsigned CI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SI_W  = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int unsigned ADR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CLR_W = $clog2(DEPTH + 1);
  localparam int unsigned CH_N  = 1 << CH_W;
  localparam int unsigned ST_N  = 1 << ST_W;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_DA = 4'd2,
                         S_EXP = 4'd3, S_INT = 4'd4, S_DB = 4'd5,
                         S_DBX = 4'd6, S_EH = 4'd7, S_CH = 4'd8,
                         S_ACC = 4'd9, S_RD = 4'd10;

  logic [3:0]        state_r;
  logic [CLR_W-1:0]  clr_r;
  logic              start_r, last_r;
  logic [CH_W-1:0]   ch_r;
  logic [ADR_W-1:0]  adr_r;
  q16_t              x_r, dt_r, a_r, b_r, c_r;
  q16_t              e_r, drive_r, h_r, hnew_r;
  logic signed [63:0] prod_r;
  logic [4:0]        hi_r;
  logic [11:0]       lo_r;
  logic signed [5:0] n_r;
  logic [1:0]        nclass_r;
  acc_t              acc_r;
  logic [CH_W-1:0]   och_r;
  q16_t              y_r;

  q16_t mem [DEPTH];

  // shared multiplier operands
  logic signed [32:0] op_a, op_b;
  logic signed [65:0] mul_full;
  logic signed [63:0] mq;        // product >>> 16 (floor)
  logic signed [47:0] n_full;    // exponent part of q
  logic [ADR_W-1:0]   in_adr;
  logic [CI_W-1:0]    in_ci;
  logic [SI_W-1:0]    in_si;
  logic [CI_W-1:0]    ci_tab [CH_N];
  logic [SI_W-1:0]    si_tab [ST_N];
  logic [17:0]        t0, t1;
  logic signed [63:0] acc_sum;
  q16_t               h_sum;
  logic [31:0]        m_val;
  q16_t               e_val;
  logic               out_load;
  logic               ch_go;

  function automatic logic signed [63:0] acc_clamp(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > 64'sh7FFF_FFFF_FFFF) r = 64'sh7FFF_FFFF_FFFF;
    else if (v < -64'sh8000_0000_0000) r = -64'sh8000_0000_0000;
    else r = v;
    return r;
  endfunction

  // index wrap tables, folded at elaboration
  for (genvar g = 0; g < CH_N; g++) begin : g_ci_tab
    assign ci_tab[g] = CI_W'(g % CHANNELS);
  end
  for (genvar g = 0; g < ST_N; g++) begin : g_si_tab
    assign si_tab[g] = SI_W'(g % STATES);
  end

  assign in_ci  = ci_tab[in_tdata[5:0]];
  assign in_si  = si_tab[in_tdata[9:6]];
  assign in_adr = ADR_W'(32'(in_ci) * STATES + 32'(in_si));

  always_comb begin
    op_a = '0; op_b = '0;
    unique case (state_r)
      S_DA:  begin op_a = 33'(dt_r); op_b = 33'(a_r); end
      S_EXP: begin op_a = 33'(sat32(prod_r)); op_b = $signed({15'd0, LOG2E_Q16}); end
      S_INT: begin op_a = $signed({15'd0, t1 - t0}); op_b = $signed({21'd0, lo_r}); end
      S_DB:  begin op_a = 33'(dt_r); op_b = 33'(b_r); end
      S_DBX: begin op_a = 33'(sat32(prod_r)); op_b = 33'(x_r); end
      S_EH:  begin op_a = 33'(e_r); op_b = 33'(h_r); end
      S_CH:  begin op_a = 33'(c_r); op_b = 33'(hnew_r); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end
  assign mul_full = op_a * op_b;
  assign mq       = 64'($signed(mul_full[65:FRAC_W]));
  assign n_full   = mq[63:16];

  assign t0      = pow2_tab(hi_r);
  assign t1      = pow2_tab(hi_r + 5'd1);
  assign m_val   = 32'(t0) + 32'(prod_r[63:12]);
  assign h_sum   = sat32(prod_r + 64'(drive_r));
  assign acc_sum = 64'(acc_r) + mq;

  always_comb begin
    unique case (nclass_r)
      2'd0: e_val = 32'sh7FFF_FFFF;
      2'd1: e_val = q16_t'(m_val << n_r[3:0]);
      2'd2: e_val = q16_t'(m_val >> (-n_r));
      default: e_val = '0;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tdata = {2'b00, y_r, och_r};

  // a result can only move into the output register once the old one is gone
  assign ch_go    = !last_r || !(out_tvalid && !out_tready);
  assign out_load = (state_r == S_CH) && last_r && ch_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      out_tvalid <= 1'b0;
      acc_r      <= '0;
    end else begin
      if (out_load) out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          mem[clr_r[ADR_W-1:0]] <= '0;
          clr_r <= clr_r + 1'b1;
          if (clr_r == CLR_W'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            start_r <= in_tuser;
            ch_r    <= in_tdata[5:0];
            last_r  <= in_tlast;
            x_r     <= in_tdata[41:10];
            dt_r    <= in_tdata[73:42];
            a_r     <= in_tdata[105:74];
            b_r     <= in_tdata[137:106];
            c_r     <= in_tdata[169:138];
            adr_r   <= in_adr;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          h_r     <= start_r ? '0 : mem[adr_r];
          state_r <= S_DA;
        end
        S_DA: begin prod_r <= mq; state_r <= S_EXP; end
        S_EXP: begin
          // q = p*log2e floor; n = q>>>16, r = q[15:0]
          n_r      <= (n_full >= 48'sd15) ? 6'sd15 :
                      (n_full <= -48'sd31) ? -6'sd31 : 6'(n_full);
          nclass_r <= (n_full >= 48'sd15) ? 2'd0 :
                      (n_full >= 48'sd0) ? 2'd1 :
                      (n_full <= -48'sd31) ? 2'd3 : 2'd2;
          hi_r     <= {1'b0, mq[15:12]};
          lo_r     <= mq[11:0];
          state_r  <= S_INT;
        end
        S_INT: begin
          // unshifted product: (t1-t0)*lo
          prod_r  <= 64'(mul_full);
          state_r <= S_DB;
        end
        S_DB: begin
          e_r     <= e_val;
          prod_r  <= mq;
          state_r <= S_DBX;
        end
        S_DBX: begin drive_r <= sat32(mq); state_r <= S_EH; end
        S_EH:  begin prod_r <= mq; state_r <= S_ACC; end
        S_ACC: begin
          hnew_r       <= h_sum;
          mem[adr_r]   <= h_sum;
          state_r      <= S_CH;
        end
        S_CH: begin
          if (ch_go) begin
            if (last_r) begin
              och_r <= ch_r;
              y_r   <= sat32(acc_clamp(acc_sum));
              acc_r <= '0;
            end else begin
              acc_r <= ACC_W'(acc_clamp(acc_sum));
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/sssc_checker.sv
// Port-level checks for the selective scan core.
// Depends on sssc_pkg; bound to selective_state_space_scan_core.
module sssc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sssc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sssc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accept");

  a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without work");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:38] == 2'b00)
    else $error("pad bits set");
endmodule

bind selective_state_space_scan_core sssc_checker u_sssc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

FILE: tb/sv/tb_top.sv
// Testbench for selective_state_space_scan_core: random and directed scan elements,
// checked against a built-in model of the Q16.16 scan. Depends on sssc_pkg.
class scan_scoreboard;
  logic signed [31:0] hstore [1024];
  logic signed [47:0] acc;
  logic [37:0] pending [$];
  int errors;
  int results;

  function new();
    for (int i = 0; i < 1024; i++) hstore[i] = 0;
    acc = 0;
    errors = 0;
    results = 0;
  endfunction

  // floor(v * w / 2^16)
  function automatic logic signed [63:0] qmul(logic signed [63:0] v, logic signed [63:0] w);
    logic signed [127:0] p;
    p = 128'(v) * 128'(w);
    return 64'(p >>> 16);
  endfunction

  function automatic logic signed [63:0] sat32(logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  function automatic logic signed [63:0] pow2(int i);
    int t [17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
                   92682, 96785, 101070, 105545, 110218, 115065, 120152, 125434, 131072};
    return t[i];
  endfunction

  function automatic logic signed [63:0] fx_exp(logic signed [63:0] p);
    logic signed [63:0] q, n, r, m, lo;
    int hi;
    q = (p * 64'sd94548) >>> 16;
    n = q >>> 16;
    r = q - n * 65536;
    hi = int'((r >> 12) & 15);
    lo = r & 64'hFFF;
    m = pow2(hi) + (((pow2(hi + 1) - pow2(hi)) * lo) >>> 12);
    if (n >= 15) return 64'sh7FFFFFFF;
    if (n >= 0) return m <<< n;
    if (n <= -31) return 0;
    return m >>> (-n);
  endfunction

  function void note_item(bit st, bit last, logic [175:0] d);
    logic signed [63:0] x, dt, a, b, c, hold, e, drv, hn, s;
    logic [9:0] idx;
    idx = {d[5:0], d[9:6]};
    x = 64'(signed'(d[41:10]));
    dt = 64'(signed'(d[73:42]));
    a = 64'(signed'(d[105:74]));
    b = 64'(signed'(d[137:106]));
    c = 64'(signed'(d[169:138]));
    hold = st ? 0 : 64'(hstore[idx]);
    e = fx_exp(sat32(qmul(dt, a)));
    drv = sat32(qmul(sat32(qmul(dt, b)), x));
    hn = sat32(qmul(e, hold) + drv);
    hstore[idx] = hn[31:0];
    s = 64'(acc) + qmul(c, hn);
    if (s > 64'sh7FFFFFFFFFFF) s = 64'sh7FFFFFFFFFFF;
    if (s < -64'sh800000000000) s = -64'sh800000000000;
    acc = s[47:0];
    if (last) begin
      s = sat32(s);
      pending.push_back({s[31:0], d[5:0]});
      acc = 0;
    end
  endfunction

  function void check_result(logic [39:0] d);
    logic [37:0] w;
    results++;
    if (pending.size() == 0) begin
      $error("unexpected result item %h", d);
      errors++;
      return;
    end
    w = pending.pop_front();
    if (d[5:0] !== w[5:0]) begin
      $error("out_channel expected %0d actual %0d", w[5:0], d[5:0]);
      errors++;
    end
    if (d[37:6] !== w[37:6]) begin
      $error("y_value expected %h actual %h", w[37:6], d[37:6]);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [sssc_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [sssc_pkg::OUT_DATA_W-1:0] out_tdata;
  scan_scoreboard sb;
  int cycles = 0;
  int sent = 0;

  always #2 clk = ~clk;

  selective_state_space_scan_core DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL selective_state_space_scan_core");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) sb.note_item(in_tuser, in_tlast, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver stall pattern: phases of always ready, random, and mostly stalled
  always @(negedge clk) begin
    if ((cycles % 3000) < 1000) out_tready <= 1'b1;
    else if ((cycles % 3000) < 2000) out_tready <= ($urandom_range(0, 1) == 1);
    else out_tready <= ($urandom_range(0, 7) == 0);
  end

  function automatic logic [31:0] rand_q();
    unique case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom();
      default: return 32'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  task automatic send_item(bit st, logic [5:0] ch, logic [3:0] si, bit last,
                           logic [31:0] x, logic [31:0] dt, logic [31:0] a,
                           logic [31:0] b, logic [31:0] c);
    in_tdata <= {6'b0, c, b, a, dt, x, si, ch};
    in_tuser <= st;
    in_tlast <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic idle_gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  initial begin
    int nst, drain;
    logic [5:0] ch;
    logic [31:0] dt;
    sb = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: extremes, sequence start, missing last, large decay
    send_item(1'b1, 6'd0, 4'd0, 1'b1, 32'h00010000, 32'h00010000, 32'hFFFF0000,
              32'h00010000, 32'h00010000);
    send_item(1'b0, 6'd0, 4'd0, 1'b1, 32'h00010000, 32'h00010000, 32'hFFFF0000,
              32'h00010000, 32'h00010000);
    send_item(1'b0, 6'd63, 4'd15, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF);
    send_item(1'b0, 6'd63, 4'd15, 1'b1, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000);
    send_item(1'b0, 6'd5, 4'd3, 1'b0, 32'h7FFFFFFF, 32'h00100000, 32'h00050000,
              32'h7FFFFFFF, 32'h7FFFFFFF);
    send_item(1'b0, 6'd9, 4'd4, 1'b0, 32'h7FFFFFFF, 32'h00100000, 32'h00050000,
              32'h7FFFFFFF, 32'h7FFFFFFF);
    send_item(1'b1, 6'd9, 4'd5, 1'b1, 32'h7FFFFFFF, 32'h00100000, 32'h00050000,
              32'h7FFFFFFF, 32'h7FFFFFFF);
    send_item(1'b0, 6'd1, 4'd1, 1'b1, 32'hFFFFFFFF, 32'h00008000, 32'hFFE00000,
              32'h00000001, 32'hFFFFFFFF);
    send_item(1'b1, 6'd42, 4'd10, 1'b1, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
              32'hAAAAAAAA, 32'h55555555);
    send_item(1'b0, 6'd21, 4'd5, 1'b1, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
              32'h55555555, 32'hAAAAAAAA);
    // random: mostly well-formed channel sweeps over states, some noise
    while (sent < 1260) begin
      ch = 6'($urandom());
      nst = $urandom_range(1, 16);
      dt = rand_q();
      for (int s = 0; s < nst; s++) begin
        bit lst;
        lst = (s == nst - 1) && ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 15) == 0) begin
          send_item(1'($urandom()), 6'($urandom()), 4'($urandom()), 1'($urandom()),
                    rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
        end else begin
          send_item($urandom_range(0, 5) == 0, ch, 4'(s), lst, rand_q(), dt, rand_q(),
                    rand_q(), rand_q());
        end
        idle_gap();
      end
    end
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    drain = 0;
    while (drain < 50) begin
      @(negedge clk);
      drain++;
    end
    $display("Sent %0d scan elements, checked %0d channel outputs.", sent, sb.results);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS selective_state_space_scan_core");
    else $display("FAIL selective_state_space_scan_core");
    $finish;
  end
endmodule
